FILE: design/sir_pkg.sv
package sir_pkg;

    // Field widths
    localparam int VAL_W  = 48;
    localparam int POP_W  = 32;
    localparam int RATE_W = 16;
    localparam int ACT_W  = 2;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 32;

    localparam int FRAC_BITS_DEF = 16;

    // Shared multiplier: VAL_W x DIGIT_W per cycle
    localparam int DIGIT_W = RATE_W;
    localparam int MUL_W   = VAL_W + DIGIT_W;
    localparam int SI_W    = 2 * VAL_W;
    localparam int PB_W    = SI_W + RATE_W;

    // Sequencer step counts
    localparam int MUL_SI_STEPS = VAL_W / DIGIT_W;
    localparam int MUL_B_STEPS  = SI_W / VAL_W;
    localparam int DIV_STEPS    = VAL_W;
    localparam int CNT_W        = $clog2(DIV_STEPS);
    localparam int STEP_IDX_W   = 2;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_STEP     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_ALL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD_INF = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE     = 2'd3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_POPULATION = 2'd0;
    localparam logic [IDX_W-1:0] REG_INF_RATE   = 2'd1;
    localparam logic [IDX_W-1:0] REG_REC_RATE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SI,
        ST_MUL_B,
        ST_RECOV,
        ST_DIV_CHK,
        ST_DIV,
        ST_COMMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_SI,
        OP_MUL_B,
        OP_RECOV,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_COMMIT_STEP,
        OP_LOAD_ALL,
        OP_LOAD_INF,
        OP_HOLD
    } dp_op_t;

    typedef struct packed {
        logic                  capture;
        dp_op_t                op;
        logic [STEP_IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic skip_div;
    } dp_status_t;

endpackage

FILE: design/sir_if.sv
// Command channel: one action word per item
interface sir_in_if import sir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [VAL_W-1:0] sus_in;
    logic [VAL_W-1:0] inf_in;
    logic [VAL_W-1:0] rec_in;

    modport source (output valid, action, sus_in, inf_in, rec_in, input ready);
    modport sink   (input valid, action, sus_in, inf_in, rec_in, output ready);
endinterface

// Result channel: counts after each item
interface sir_out_if import sir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] sus_out;
    logic [VAL_W-1:0] inf_out;
    logic [VAL_W-1:0] rec_out;
    logic             saturated;

    modport source (output valid, sus_out, inf_out, rec_out, saturated, input ready);
    modport sink   (input valid, sus_out, inf_out, rec_out, saturated, output ready);
endinterface

FILE: design/sir_dp.sv
module sir_dp import sir_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0] wr_data,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  logic [VAL_W-1:0] sus_in,
    input  logic [VAL_W-1:0] inf_in,
    input  logic [VAL_W-1:0] rec_in,
    output logic [VAL_W-1:0] sus_out,
    output logic [VAL_W-1:0] inf_out,
    output logic [VAL_W-1:0] rec_out,
    output logic             saturated
);

    localparam int SHIFT  = 2 * FRAC_BITS;
    localparam int HI_W   = PB_W - SHIFT - VAL_W;
    localparam int CMP_W  = (HI_W > POP_W) ? HI_W : POP_W;
    localparam int POPN_W = POP_W + FRAC_BITS;
    localparam int LOAD_W = (POPN_W > VAL_W + 1) ? POPN_W : VAL_W + 1;

    // Configuration
    logic [POP_W-1:0]  pop_reg;
    logic [RATE_W-1:0] beta_reg;
    logic [RATE_W-1:0] gamma_reg;

    // Model state
    logic [VAL_W-1:0] sus_reg, sus_next;
    logic [VAL_W-1:0] inf_reg, inf_next;
    logic [VAL_W-1:0] rec_reg, rec_next;

    // Captured word
    logic [VAL_W-1:0] ld_sus_reg, ld_inf_reg, ld_rec_reg;

    // Working registers
    logic [SI_W-1:0]  prod_reg, prod_next;
    logic [PB_W-1:0]  pb_reg, pb_next;
    logic [VAL_W-1:0] recov_reg, recov_next;
    logic             rsat_reg, rsat_next;
    logic [POP_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic             skip_reg, skip_next;

    // Output word
    logic [VAL_W-1:0] sus_out_reg, inf_out_reg, rec_out_reg;
    logic             sat_out_reg, sat_next;
    logic             out_load;

    // Shared multiplier
    logic [VAL_W-1:0]   mul_a;
    logic [DIGIT_W-1:0] mul_b;
    logic [MUL_W-1:0]   mul_p;

    // Recovery term
    logic [MUL_W-1:0] rv;

    // Divider setup and step
    logic [HI_W-1:0]  div_hi;
    logic [VAL_W-1:0] div_lo;
    logic [POP_W:0]   div_t;
    logic [POP_W:0]   div_diff;
    logic             div_ge;

    // Step commit
    logic             infect_sat;
    logic [VAL_W-1:0] infect;
    logic [VAL_W+1:0] ni;
    logic             ni_sat;
    logic [VAL_W:0]   nr;

    // Full load with derived susceptible
    logic [LOAD_W-1:0] n_full;
    logic              n_sat;
    logic [VAL_W-1:0]  n_cl;
    logic [VAL_W:0]    used;
    logic              under;
    logic              derive;

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_SI:
            begin
                mul_a = sus_reg;
                mul_b = DIGIT_W'(inf_reg >> (DIGIT_W * int'(cmd.idx)));
            end
            OP_MUL_B:
            begin
                mul_a = VAL_W'(prod_reg >> (VAL_W * int'(cmd.idx)));
                mul_b = beta_reg;
            end
            OP_RECOV:
            begin
                mul_a = inf_reg;
                mul_b = gamma_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign rv    = mul_p >> FRAC_BITS;

    // Divider terms
    assign div_hi   = pb_reg[PB_W-1 -: HI_W];
    assign div_lo   = pb_reg[SHIFT +: VAL_W];
    assign div_t    = {rem_reg, quo_reg[VAL_W-1]};
    assign div_ge   = div_t >= {1'b0, pop_reg};
    assign div_diff = div_t - {1'b0, pop_reg};

    // Step commit terms
    assign infect_sat = skip_reg || (quo_reg > sus_reg);
    assign infect     = infect_sat ? sus_reg : quo_reg;
    assign ni         = {2'b00, inf_reg} + {2'b00, infect} - {2'b00, recov_reg};
    assign ni_sat     = ni > {2'b00, VAL_MAX};
    assign nr         = {1'b0, rec_reg} + {1'b0, recov_reg};

    // Full load terms
    assign n_full = LOAD_W'(pop_reg) << FRAC_BITS;
    assign n_sat  = n_full > LOAD_W'(VAL_MAX);
    assign n_cl   = n_sat ? VAL_MAX : n_full[VAL_W-1:0];
    assign used   = {1'b0, ld_inf_reg} + {1'b0, ld_rec_reg};
    assign under  = used > {1'b0, n_cl};
    assign derive = ld_sus_reg == '0;

    // Next-value logic per command
    always_comb
    begin
        sus_next   = sus_reg;
        inf_next   = inf_reg;
        rec_next   = rec_reg;
        prod_next  = prod_reg;
        pb_next    = pb_reg;
        recov_next = recov_reg;
        rsat_next  = rsat_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        skip_next  = skip_reg;
        sat_next   = 1'b0;
        out_load   = 1'b0;
        case (cmd.op)
            OP_MUL_SI:
            begin
                prod_next = ((cmd.idx == '0) ? '0 : prod_reg)
                          + (SI_W'(mul_p) << (DIGIT_W * int'(cmd.idx)));
            end
            OP_MUL_B:
            begin
                pb_next = ((cmd.idx == '0) ? '0 : pb_reg)
                        + (PB_W'(mul_p) << (VAL_W * int'(cmd.idx)));
            end
            OP_RECOV:
            begin
                if (rv > MUL_W'(inf_reg))
                begin
                    recov_next = inf_reg;
                    rsat_next  = 1'b1;
                end
                else
                begin
                    recov_next = VAL_W'(rv);
                    rsat_next  = 1'b0;
                end
            end
            OP_DIV_INIT:
            begin
                // quotient above 48 bits or no population: infection clamps
                skip_next = (pop_reg == '0) || (CMP_W'(div_hi) >= CMP_W'(pop_reg));
                rem_next  = POP_W'(div_hi);
                quo_next  = div_lo;
            end
            OP_DIV_STEP:
            begin
                rem_next = div_ge ? div_diff[POP_W-1:0] : div_t[POP_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], div_ge};
            end
            OP_COMMIT_STEP:
            begin
                sus_next = sus_reg - infect;
                inf_next = ni_sat ? VAL_MAX : ni[VAL_W-1:0];
                rec_next = nr[VAL_W] ? VAL_MAX : nr[VAL_W-1:0];
                sat_next = infect_sat | rsat_reg | ni_sat | nr[VAL_W];
                out_load = 1'b1;
            end
            OP_LOAD_ALL:
            begin
                inf_next = ld_inf_reg;
                rec_next = ld_rec_reg;
                if (!derive)
                begin
                    sus_next = ld_sus_reg;
                end
                else if (under)
                begin
                    sus_next = '0;
                end
                else
                begin
                    sus_next = n_cl - used[VAL_W-1:0];
                end
                sat_next = derive & (n_sat | under);
                out_load = 1'b1;
            end
            OP_LOAD_INF:
            begin
                inf_next = ld_inf_reg;
                out_load = 1'b1;
            end
            OP_HOLD:
            begin
                out_load = 1'b1;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Configuration and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_reg   <= POP_W'(1);
            beta_reg  <= '0;
            gamma_reg <= '0;
            sus_reg   <= '0;
            inf_reg   <= '0;
            rec_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_POPULATION: pop_reg   <= wr_data[POP_W-1:0];
                    REG_INF_RATE:   beta_reg  <= wr_data[RATE_W-1:0];
                    REG_REC_RATE:   gamma_reg <= wr_data[RATE_W-1:0];
                    default:        pop_reg   <= pop_reg;
                endcase
            end
            sus_reg <= sus_next;
            inf_reg <= inf_next;
            rec_reg <= rec_next;
        end
    end

    // Working and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ld_sus_reg <= sus_in;
            ld_inf_reg <= inf_in;
            ld_rec_reg <= rec_in;
        end
        prod_reg  <= prod_next;
        pb_reg    <= pb_next;
        recov_reg <= recov_next;
        rsat_reg  <= rsat_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        skip_reg  <= skip_next;
        if (out_load)
        begin
            sus_out_reg <= sus_next;
            inf_out_reg <= inf_next;
            rec_out_reg <= rec_next;
            sat_out_reg <= sat_next;
        end
    end

    assign status.skip_div = skip_reg;
    assign sus_out   = sus_out_reg;
    assign inf_out   = inf_out_reg;
    assign rec_out   = rec_out_reg;
    assign saturated = sat_out_reg;

endmodule

FILE: design/sir_ctrl.sv
module sir_ctrl import sir_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [ACT_W-1:0] in_action,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output dp_cmd_t          cmd,
    input  dp_status_t       status
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACT_W-1:0] action_reg, action_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             can_commit;
    logic             commit;

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign can_commit = !out_valid_reg || out_ready;
    assign commit     = (state_reg == ST_COMMIT) && can_commit;

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        action_next = accept ? in_action : action_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = (in_action == ACT_STEP) ? ST_MUL_SI : ST_COMMIT;
                end
            end
            ST_MUL_SI:
            begin
                if (cnt_reg == CNT_W'(MUL_SI_STEPS - 1))
                begin
                    state_next = ST_MUL_B;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL_B:
            begin
                if (cnt_reg == CNT_W'(MUL_B_STEPS - 1))
                begin
                    state_next = ST_RECOV;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RECOV:
            begin
                state_next = ST_DIV_CHK;
            end
            ST_DIV_CHK:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                if (status.skip_div || (cnt_reg == CNT_W'(DIV_STEPS - 1)))
                begin
                    state_next = ST_COMMIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (can_commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd.capture = accept;
        cmd.idx     = cnt_reg[STEP_IDX_W-1:0];
        cmd.op      = OP_NONE;
        case (state_reg)
            ST_MUL_SI:  cmd.op = OP_MUL_SI;
            ST_MUL_B:   cmd.op = OP_MUL_B;
            ST_RECOV:   cmd.op = OP_RECOV;
            ST_DIV_CHK: cmd.op = OP_DIV_INIT;
            ST_DIV:     cmd.op = status.skip_div ? OP_NONE : OP_DIV_STEP;
            ST_COMMIT:
            begin
                if (can_commit)
                begin
                    case (action_reg)
                        ACT_STEP:     cmd.op = OP_COMMIT_STEP;
                        ACT_LOAD_ALL: cmd.op = OP_LOAD_ALL;
                        ACT_LOAD_INF: cmd.op = OP_LOAD_INF;
                        default:      cmd.op = OP_HOLD;
                    endcase
                end
            end
            default:    cmd.op = OP_NONE;
        endcase
    end

    // Result word handshake
    assign out_valid_next = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            action_reg    <= ACT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            action_reg    <= action_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    // a full result buffer holds the commit back
    a_commit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && out_valid_reg && !out_ready) |=> state_reg == ST_COMMIT)
        else $error("commit left while result word still pending");

    // a new result word only comes from a commit
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_COMMIT)
        else $error("result valid without commit");

    // a step word starts the multiply sequence at digit zero
    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_action == ACT_STEP) |=> (state_reg == ST_MUL_SI && cnt_reg == '0))
        else $error("step did not start multiply sequence");

    // divider count stays within its quotient bits
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg < CNT_W'(DIV_STEPS))
        else $error("divider count out of range");
`endif

endmodule

FILE: design/sir_epidemic_step.sv
// Discrete SIR epidemic step. Holds susceptible, infected and recovered counts
// as unsigned fixed point (FRAC_BITS fraction bits, 48-bit words). Each command
// word returns one result word with the counts after it. A load (full or
// infected only) goes from acceptance straight to the commit state. A step
// runs acceptance, 3 multiply passes for S*I on the shared 48x16 multiplier,
// 2 for the infection rate, 1 for recovery, 1 divider setup, 48 restoring
// divider steps by the population (one quotient bit per cycle), and the
// commit; the divider is skipped when the population is 0 or the quotient
// would exceed 48 bits. One word is worked on at a time; the next command
// is taken when the block returns to idle, while the last result may still
// wait in its output register. Configuration writes go through
// wr_en/wr_index/wr_data: 0 population, 1 infection rate, 2 recovery rate.
module sir_epidemic_step import sir_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0] wr_data,
    sir_in_if.sink           cmd,
    sir_out_if.source        result
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       in_ready;
    logic       out_valid;

    sir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_action (cmd.action),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    sir_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .sus_in    (cmd.sus_in),
        .inf_in    (cmd.inf_in),
        .rec_in    (cmd.rec_in),
        .sus_out   (result.sus_out),
        .inf_out   (result.inf_out),
        .rec_out   (result.rec_out),
        .saturated (result.saturated)
    );

    assign cmd.ready    = in_ready;
    assign result.valid = out_valid;

endmodule
